[src/pwi_pkg.sv]
// shared constants, register codes and helpers for the pillar wall unit
package pwi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 4;
	localparam int CFG_DATA_W    = 64;
	// magnitude width of every dividend and divisor
	localparam int DIV_NW        = 34;
	// width of a saturated quotient or product (holds +-2^47)
	localparam int Q_W           = 49;
	// low slice width of the split multiplier operand
	localparam int MUL_LO_W      = 24;
	// width the partial products are summed in
	localparam int MUL_EXT_W     = 96;
	localparam int OUT_W_W       = 18;
	localparam int WALL_U_W      = 17;
	// reset depth of a pillar end point
	localparam logic [31:0] Z_END_RST = 32'h0001_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P0_START_XY = 4'd0,
		REG_P0_START_Z  = 4'd1,
		REG_P0_END_XY   = 4'd2,
		REG_P0_END_Z    = 4'd3,
		REG_P1_START_XY = 4'd4,
		REG_P1_START_Z  = 4'd5,
		REG_P1_END_XY   = 4'd6,
		REG_P1_END_Z    = 4'd7
	} cfg_reg_t;

	// saturate to 32 bits signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7fff_ffff;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			return 32'sh7fff_ffff;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

[src/pillar_wall_intersect_normal_core.sv]
// top level of the pillar wall intersect / normal unit
// Takes one item per cycle while in_ready is high (Q16.16 by default). Two
// chained dividers settle one quotient bit per stage (the crossing parameter,
// then the pillar fractions and slopes). A two-entry output buffer lets the
// pipeline keep accepting while a result waits; in_ready drops only when both
// entries are full. Pillar registers are read live by the pipeline, so the
// user must see that they are written only while no item is in flight; the
// block does not enforce this. The configuration port never stalls.
module pillar_wall_intersect_normal_core #(
	parameter int FRAC_BITS = pwi_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic signed [31:0]                line_a_start_z,
	input  logic signed [31:0]                line_a_end_z,
	input  logic signed [31:0]                line_b_start_z,
	input  logic signed [31:0]                line_b_end_z,
	input  logic [pwi_pkg::WALL_U_W-1:0]      wall_u,
	input  logic signed [31:0]                sample_depth,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                out_x,
	output logic signed [31:0]                out_y,
	output logic signed [31:0]                out_z,
	output logic [pwi_pkg::OUT_W_W-1:0]       out_w,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pwi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pwi_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int NW      = pwi_pkg::DIV_NW;
	localparam int QWS     = pwi_pkg::Q_W;
	localparam int GW      = QWS + 1;
	localparam int UW      = FRAC_BITS + 2;
	localparam int CW      = (UW > pwi_pkg::WALL_U_W) ? UW : pwi_pkg::WALL_U_W;
	localparam int DIV_LAT = NW + FRAC_BITS + 2;
	localparam int MUL_LAT = 2;
	localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
	localparam logic signed [QWS-1:0] ONE_Q = QWS'(1) <<< FRAC_BITS;
	localparam logic [63:0] THREE_Q = 64'(3) << FRAC_BITS;

	typedef struct packed {
		logic                 v;
		logic                 mode;
		logic signed [31:0]   az0;
		logic signed [32:0]   da;
		logic signed [UW-1:0] un;
		logic signed [31:0]   w;
	} sb_a_t;

	typedef struct packed {
		logic                 v;
		logic                 mode;
		logic signed [31:0]   az0;
		logic signed [UW-1:0] u;
		logic signed [31:0]   w;
	} sb_b_t;

	typedef struct packed {
		logic                 v;
		logic                 mode;
		logic signed [UW-1:0] u;
		logic signed [31:0]   z;
	} sb_c_t;

	typedef struct packed {
		logic                 v;
		logic                 mode;
		logic signed [UW-1:0] u;
		logic signed [31:0]   z;
		logic signed [QWS-1:0] sx0;
		logic signed [QWS-1:0] sy0;
	} sb_d_t;

	typedef struct packed {
		logic                 v;
		logic                 mode;
		logic signed [UW-1:0] u;
		logic signed [31:0]   z;
		logic signed [31:0]   px0;
		logic signed [31:0]   py0;
		logic signed [32:0]   dvx;
		logic signed [32:0]   dvy;
	} sb_f_t;

	typedef struct packed {
		logic signed [31:0]            x;
		logic signed [31:0]            y;
		logic signed [31:0]            z;
		logic [pwi_pkg::OUT_W_W-1:0]   w;
	} res_t;

	// pillar registers
	logic [63:0] p0s_xy_q, p0e_xy_q, p1s_xy_q, p1e_xy_q;
	logic [31:0] p0s_z_q, p0e_z_q, p1s_z_q, p1e_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0s_xy_q <= '0;
			p0s_z_q  <= '0;
			p0e_xy_q <= '0;
			p0e_z_q  <= pwi_pkg::Z_END_RST;
			p1s_xy_q <= '0;
			p1s_z_q  <= '0;
			p1e_xy_q <= '0;
			p1e_z_q  <= pwi_pkg::Z_END_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pwi_pkg::REG_P0_START_XY: p0s_xy_q <= cfg_data;
				pwi_pkg::REG_P0_START_Z:  p0s_z_q  <= cfg_data[31:0];
				pwi_pkg::REG_P0_END_XY:   p0e_xy_q <= cfg_data;
				pwi_pkg::REG_P0_END_Z:    p0e_z_q  <= cfg_data[31:0];
				pwi_pkg::REG_P1_START_XY: p1s_xy_q <= cfg_data;
				pwi_pkg::REG_P1_START_Z:  p1s_z_q  <= cfg_data[31:0];
				pwi_pkg::REG_P1_END_XY:   p1e_xy_q <= cfg_data;
				pwi_pkg::REG_P1_END_Z:    p1e_z_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// pillar geometry seen by the pipeline
	logic signed [31:0] xs0, ys0, xe0, ye0, sz0, ez0;
	logic signed [31:0] xs1, ys1, xe1, ye1, sz1, ez1;
	logic signed [32:0] dx0, dy0, h0, dx1, dy1, h1;

	assign xs0 = p0s_xy_q[63:32];
	assign ys0 = p0s_xy_q[31:0];
	assign xe0 = p0e_xy_q[63:32];
	assign ye0 = p0e_xy_q[31:0];
	assign sz0 = p0s_z_q;
	assign ez0 = p0e_z_q;
	assign xs1 = p1s_xy_q[63:32];
	assign ys1 = p1s_xy_q[31:0];
	assign xe1 = p1e_xy_q[63:32];
	assign ye1 = p1e_xy_q[31:0];
	assign sz1 = p1s_z_q;
	assign ez1 = p1e_z_q;
	assign dx0 = 33'(xe0) - 33'(xs0);
	assign dy0 = 33'(ye0) - 33'(ys0);
	assign h0  = 33'(ez0) - 33'(sz0);
	assign dx1 = 33'(xe1) - 33'(xs1);
	assign dy1 = 33'(ye1) - 33'(ys1);
	assign h1  = 33'(ez1) - 33'(sz1);

	// pipeline advance, held only when the output buffer is full
	logic [1:0] cnt_q;
	logic       en;

	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	// input stage
	logic               v_s1;
	logic               mode_s1;
	logic signed [31:0] az0_s1, az1_s1, bz0_s1, bz1_s1, w_s1;
	logic [pwi_pkg::WALL_U_W-1:0] wu_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			az0_s1  <= line_a_start_z;
			az1_s1  <= line_a_end_z;
			bz0_s1  <= line_b_start_z;
			bz1_s1  <= line_b_end_z;
			wu_s1   <= wall_u;
			w_s1    <= sample_depth;
		end
	end

	// crossing parameter division
	logic signed [NW-1:0]  n1, dn1;
	logic signed [32:0]    da1;
	logic [CW-1:0]         wu_ext, un_c;
	sb_a_t                 sba_in, sba_out;
	logic signed [QWS-1:0] qu;

	assign da1    = 33'(az1_s1) - 33'(az0_s1);
	assign n1     = NW'(bz0_s1) - NW'(az0_s1);
	assign dn1    = NW'(da1) - (NW'(bz1_s1) - NW'(bz0_s1));
	assign wu_ext = CW'(wu_s1);
	assign un_c   = (wu_ext > ONE_C) ? ONE_C : wu_ext;

	assign sba_in.v    = v_s1;
	assign sba_in.mode = mode_s1;
	assign sba_in.az0  = az0_s1;
	assign sba_in.da   = da1;
	assign sba_in.un   = UW'(un_c);
	assign sba_in.w    = w_s1;

	pwi_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
		.clk(clk), .en(en), .num(n1), .den(dn1), .quo(qu)
	);

	pwi_delay #(.W($bits(sb_a_t)), .N(DIV_LAT)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .en(en), .din(sba_in), .dout(sba_out)
	);

	// clamp u and form the crossing depth product
	logic signed [QWS-1:0] uc_w;
	logic signed [UW-1:0]  uc;
	logic signed [QWS-1:0] mz;
	sb_b_t                 sbb_in, sbb_out;

	assign uc_w = (qu < 0) ? '0 : ((qu > ONE_Q) ? ONE_Q : qu);
	assign uc   = UW'(uc_w);

	assign sbb_in.v    = sba_out.v;
	assign sbb_in.mode = sba_out.mode;
	assign sbb_in.az0  = sba_out.az0;
	assign sbb_in.u    = sba_out.mode ? sba_out.un : uc;
	assign sbb_in.w    = sba_out.w;

	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(UW), .BW(33)) u_mul_z (
		.clk(clk), .en(en), .a(uc), .b(sba_out.da), .p(mz)
	);

	pwi_delay #(.W($bits(sb_b_t)), .N(MUL_LAT)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .en(en), .din(sbb_in), .dout(sbb_out)
	);

	// pillar fractions and slopes
	logic signed [31:0]    zb, depth_b;
	logic signed [QWS-1:0] t0, t1, sx0, sy0, sx1, sy1;
	sb_c_t                 sbc_in, sbc_out;

	assign zb      = pwi_pkg::sat32(64'(sbb_out.az0) + 64'(mz));
	assign depth_b = sbb_out.mode ? sbb_out.w : zb;

	assign sbc_in.v    = sbb_out.v;
	assign sbc_in.mode = sbb_out.mode;
	assign sbc_in.u    = sbb_out.u;
	assign sbc_in.z    = zb;

	pwi_div #(.FRAC_BITS(FRAC_BITS)) u_div_t0 (
		.clk(clk), .en(en), .num(NW'(depth_b) - NW'(sz0)), .den(NW'(h0)), .quo(t0)
	);
	pwi_div #(.FRAC_BITS(FRAC_BITS)) u_div_t1 (
		.clk(clk), .en(en), .num(NW'(depth_b) - NW'(sz1)), .den(NW'(h1)), .quo(t1)
	);
	pwi_div #(.FRAC_BITS(FRAC_BITS)) u_div_sx0 (
		.clk(clk), .en(en), .num(NW'(dx0)), .den(NW'(h0)), .quo(sx0)
	);
	pwi_div #(.FRAC_BITS(FRAC_BITS)) u_div_sy0 (
		.clk(clk), .en(en), .num(NW'(dy0)), .den(NW'(h0)), .quo(sy0)
	);
	pwi_div #(.FRAC_BITS(FRAC_BITS)) u_div_sx1 (
		.clk(clk), .en(en), .num(NW'(dx1)), .den(NW'(h1)), .quo(sx1)
	);
	pwi_div #(.FRAC_BITS(FRAC_BITS)) u_div_sy1 (
		.clk(clk), .en(en), .num(NW'(dy1)), .den(NW'(h1)), .quo(sy1)
	);

	pwi_delay #(.W($bits(sb_c_t)), .N(DIV_LAT)) u_dly_c (
		.clk(clk), .arst_n(arst_n), .en(en), .din(sbc_in), .dout(sbc_out)
	);

	// pillar point and slope blend products
	logic signed [QWS-1:0] mpx0, mpy0, mpx1, mpy1, mgx, mgy;
	logic signed [GW-1:0]  sdx, sdy;
	sb_d_t                 sbd_in, sbd_out;

	assign sdx = GW'(sx1) - GW'(sx0);
	assign sdy = GW'(sy1) - GW'(sy0);

	assign sbd_in.v    = sbc_out.v;
	assign sbd_in.mode = sbc_out.mode;
	assign sbd_in.u    = sbc_out.u;
	assign sbd_in.z    = sbc_out.z;
	assign sbd_in.sx0  = sx0;
	assign sbd_in.sy0  = sy0;

	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(QWS), .BW(33)) u_mul_px0 (
		.clk(clk), .en(en), .a(t0), .b(dx0), .p(mpx0)
	);
	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(QWS), .BW(33)) u_mul_py0 (
		.clk(clk), .en(en), .a(t0), .b(dy0), .p(mpy0)
	);
	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(QWS), .BW(33)) u_mul_px1 (
		.clk(clk), .en(en), .a(t1), .b(dx1), .p(mpx1)
	);
	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(QWS), .BW(33)) u_mul_py1 (
		.clk(clk), .en(en), .a(t1), .b(dy1), .p(mpy1)
	);
	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(GW), .BW(UW)) u_mul_gx (
		.clk(clk), .en(en), .a(sdx), .b(sbc_out.u), .p(mgx)
	);
	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(GW), .BW(UW)) u_mul_gy (
		.clk(clk), .en(en), .a(sdy), .b(sbc_out.u), .p(mgy)
	);

	pwi_delay #(.W($bits(sb_d_t)), .N(MUL_LAT)) u_dly_d (
		.clk(clk), .arst_n(arst_n), .en(en), .din(sbd_in), .dout(sbd_out)
	);

	// pillar points, spans and blended slopes
	logic signed [31:0]   px0_d, py0_d, px1_d, py1_d;
	logic                 v_s2, mode_s2;
	logic signed [UW-1:0] u_s2;
	logic signed [31:0]   z_s2, px0_s2, py0_s2;
	logic signed [32:0]   dvx_s2, dvy_s2;
	logic signed [GW-1:0] gx_s2, gy_s2;

	assign px0_d = pwi_pkg::sat32(64'(xs0) + 64'(mpx0));
	assign py0_d = pwi_pkg::sat32(64'(ys0) + 64'(mpy0));
	assign px1_d = pwi_pkg::sat32(64'(xs1) + 64'(mpx1));
	assign py1_d = pwi_pkg::sat32(64'(ys1) + 64'(mpy1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= sbd_out.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= sbd_out.mode;
			u_s2    <= sbd_out.u;
			z_s2    <= sbd_out.z;
			px0_s2  <= px0_d;
			py0_s2  <= py0_d;
			dvx_s2  <= 33'(px1_d) - 33'(px0_d);
			dvy_s2  <= 33'(py1_d) - 33'(py0_d);
			gx_s2   <= GW'(sbd_out.sx0) + GW'(mgx);
			gy_s2   <= GW'(sbd_out.sy0) + GW'(mgy);
		end
	end

	// final products: u blend of the points, or the normal cross terms
	logic signed [GW-1:0]  fa_a, fb_a;
	logic signed [32:0]    fa_b, fb_b;
	logic signed [QWS-1:0] ma, mb;
	sb_f_t                 sbf_in, sbf_out;

	assign fa_a = mode_s2 ? gx_s2 : GW'(u_s2);
	assign fa_b = mode_s2 ? dvy_s2 : dvx_s2;
	assign fb_a = mode_s2 ? gy_s2 : GW'(u_s2);
	assign fb_b = mode_s2 ? dvx_s2 : dvy_s2;

	assign sbf_in.v    = v_s2;
	assign sbf_in.mode = mode_s2;
	assign sbf_in.u    = u_s2;
	assign sbf_in.z    = z_s2;
	assign sbf_in.px0  = px0_s2;
	assign sbf_in.py0  = py0_s2;
	assign sbf_in.dvx  = dvx_s2;
	assign sbf_in.dvy  = dvy_s2;

	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(GW), .BW(33)) u_mul_fa (
		.clk(clk), .en(en), .a(fa_a), .b(fa_b), .p(ma)
	);
	pwi_mul #(.FRAC_BITS(FRAC_BITS), .AW(GW), .BW(33)) u_mul_fb (
		.clk(clk), .en(en), .a(fb_a), .b(fb_b), .p(mb)
	);

	pwi_delay #(.W($bits(sb_f_t)), .N(MUL_LAT)) u_dly_f (
		.clk(clk), .arst_n(arst_n), .en(en), .din(sbf_in), .dout(sbf_out)
	);

	// result assembly
	res_t        res;
	logic [63:0] ow64;

	assign ow64 = sbf_out.mode ? THREE_Q : 64'(sbf_out.u);

	always_comb begin
		if (sbf_out.mode) begin
			res.x = pwi_pkg::sat32(-64'(sbf_out.dvy));
			res.y = pwi_pkg::sat32(64'(sbf_out.dvx));
			res.z = pwi_pkg::sat32(64'(ma) - 64'(mb));
		end else begin
			res.x = pwi_pkg::sat32(64'(sbf_out.px0) + 64'(ma));
			res.y = pwi_pkg::sat32(64'(sbf_out.py0) + 64'(mb));
			res.z = sbf_out.z;
		end
		res.w = ow64[pwi_pkg::OUT_W_W-1:0];
	end

	// two-entry output buffer
	res_t ent0_q, ent1_q;
	logic push, pop;

	assign push      = en && sbf_out.v;
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_x     = ent0_q.x;
	assign out_y     = ent0_q.y;
	assign out_z     = ent0_q.z;
	assign out_w     = ent0_q.w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent0_q <= (push && cnt_q == 2'd1) ? res : ent1_q;
		end else if (push && cnt_q == 2'd0) begin
			ent0_q <= res;
		end
		if (push && ((cnt_q == 2'd1 && !pop) || (cnt_q == 2'd2 && pop))) begin
			ent1_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	// a stalled input side means results are waiting
	a_stall_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output buffer");

	// a full buffer with no beat taken stays full
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && !out_ready) |=> !in_ready)
		else $error("output buffer lost a beat");

	// a beat taken from a full buffer frees a slot
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && out_valid && out_ready) |=> in_ready)
		else $error("output buffer did not free a slot");
`endif

endmodule

[src/pwi_delay.sv]
// enable-gated delay line for data that rides beside a pipelined unit
module pwi_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [0:N-1];

	// shift one place per advancing cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				tap_s[i] <= '0;
			end
		end else if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[N-1];

endmodule

[src/pwi_div.sv]
// pipelined signed fixed point divider, one quotient bit per stage, saturating
module pwi_div #(
	parameter int FRAC_BITS = pwi_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [pwi_pkg::DIV_NW-1:0] num,
	input  logic signed [pwi_pkg::DIV_NW-1:0] den,
	output logic signed [pwi_pkg::Q_W-1:0]    quo
);

	localparam int NW = pwi_pkg::DIV_NW;
	localparam int QW = NW + FRAC_BITS;
	localparam logic [63:0] QLIM = 64'(1) << (pwi_pkg::Q_W - 2);

	logic [QW-1:0] num_s [0:QW];
	logic [NW-1:0] den_s [0:QW];
	logic [NW-1:0] rem_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic          neg_s [0:QW];
	logic          dz_s  [0:QW];
	logic [NW-1:0] un;
	logic [NW-1:0] ud;
	logic [63:0]   q64;
	logic [63:0]   qs64;
	logic signed [pwi_pkg::Q_W-1:0] res_s;

	// magnitudes and sign
	assign un = num[NW-1] ? NW'(-num) : NW'(num);
	assign ud = den[NW-1] ? NW'(-den) : NW'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= {un, {FRAC_BITS{1'b0}}};
			den_s[0] <= ud;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
			neg_s[0] <= num[NW-1] ^ den[NW-1];
			dz_s[0]  <= (den == '0);
		end
	end

	// restoring steps
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [NW:0] r2;
		logic [NW:0] diff;
		logic        ge;
		assign r2   = {rem_s[i], num_s[i][QW-1]};
		assign diff = r2 - {1'b0, den_s[i]};
		assign ge   = (r2 >= {1'b0, den_s[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1] <= {num_s[i][QW-2:0], 1'b0};
				den_s[i+1] <= den_s[i];
				rem_s[i+1] <= ge ? diff[NW-1:0] : r2[NW-1:0];
				quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
				neg_s[i+1] <= neg_s[i];
				dz_s[i+1]  <= dz_s[i];
			end
		end
	end

	// saturate, zero divisor, apply sign
	assign q64  = 64'(quo_s[QW]);
	assign qs64 = (q64 > QLIM) ? QLIM : q64;

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_s[QW]) begin
				res_s <= '0;
			end else if (neg_s[QW]) begin
				res_s <= pwi_pkg::Q_W'(64'd0 - qs64);
			end else begin
				res_s <= pwi_pkg::Q_W'(qs64);
			end
		end
	end

	assign quo = res_s;

endmodule

[src/pwi_mul.sv]
// two-stage fixed point multiplier: split partial products, then floor and saturate
module pwi_mul #(
	parameter int FRAC_BITS = pwi_pkg::FRAC_BITS_DEF,
	parameter int AW        = 33,
	parameter int BW        = 33
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [AW-1:0]           a,
	input  logic signed [BW-1:0]           b,
	output logic signed [pwi_pkg::Q_W-1:0] p
);

	localparam int LO = (AW > pwi_pkg::MUL_LO_W + 1) ? pwi_pkg::MUL_LO_W : AW - 1;
	localparam int HW = AW - LO;
	localparam int EW = pwi_pkg::MUL_EXT_W;
	localparam logic signed [EW-1:0] P_MAX = (EW'(1) <<< 63) - EW'(1);
	localparam logic signed [EW-1:0] LIM   = EW'(1) <<< (pwi_pkg::Q_W - 2);

	logic signed [LO+BW:0]   pl_s1;
	logic signed [HW+BW-1:0] ph_s1;
	logic signed [EW-1:0]    sum;
	logic signed [EW-1:0]    shr;
	logic signed [EW-1:0]    sat;
	logic signed [pwi_pkg::Q_W-1:0] res_s2;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= $signed({1'b0, a[LO-1:0]}) * b;
			ph_s1 <= $signed(a[AW-1:LO]) * b;
		end
	end

	// recombine, floor, saturate
	assign sum = (EW'(ph_s1) <<< LO) + EW'(pl_s1);
	assign shr = sum >>> FRAC_BITS;

	always_comb begin
		if (sum > P_MAX) begin
			sat = LIM;
		end else if (sum < -P_MAX) begin
			sat = -LIM;
		end else if (shr > LIM) begin
			sat = LIM;
		end else if (shr < -LIM) begin
			sat = -LIM;
		end else begin
			sat = shr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= sat[pwi_pkg::Q_W-1:0];
		end
	end

	assign p = res_s2;

endmodule
